// ----- sv/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Sizes of the region table and the frame stacks, the request and result
// items, and saturating counter helpers.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int DIRTY_DEPTH = 1024;
  localparam int POOL_DEPTH  = 1024;
  localparam int FRAME_BITS  = 40;

  localparam int REG_AW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int REG_CW   = $clog2(MAX_REGIONS + 1);
  localparam int DIRTY_AW = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
  localparam int DIRTY_CW = $clog2(DIRTY_DEPTH + 1);
  localparam int POOL_AW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int POOL_CW  = $clog2(POOL_DEPTH + 1);

  localparam logic [2:0] FUNC_ALLOC  = 3'd0;
  localparam logic [2:0] FUNC_FREE   = 3'd1;
  localparam logic [2:0] FUNC_CONTIG = 3'd2;
  localparam logic [2:0] FUNC_ZERO   = 3'd3;
  localparam logic [2:0] FUNC_ADD    = 3'd4;

  localparam logic [1:0] ST_UNCHANGED = 2'd0;
  localparam logic [1:0] ST_ACTIVE    = 2'd1;
  localparam logic [1:0] ST_FREE      = 2'd2;
  localparam logic [1:0] ST_ZEROED    = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_REJECTED = 2'd1;
  localparam logic [1:0] ERR_LEAKED   = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [39:0] frame;
    logic [31:0] count;
  } pfa_req_t;

  typedef struct packed {
    logic        ok;
    logic [39:0] run_frame;
    logic [31:0] run_pages;
    logic [31:0] zero_pages;
    logic [1:0]  new_state;
    logic [31:0] free_total;
    logic [31:0] low_water_mark;
    logic [10:0] dirty_depth_now;
    logic [10:0] pool_depth_now;
    logic [31:0] tail_zeroed_total;
    logic [31:0] failure_total;
    logic [1:0]  error_code;
  } pfa_rsp_t;

  typedef enum logic [2:0] {
    OP_ALLOC, OP_FREE, OP_CONTIG, OP_ZERO, OP_ADD, OP_NONE
  } pfa_op_e;

  typedef struct packed {
    pfa_op_e               op;
    logic [FRAME_BITS-1:0] frame;
    logic [31:0]           count;
  } pfa_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_TRIM, S_SCAN_C, S_SCAN_Z, S_RESULT
  } pfa_state_e;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
    return (a < b) ? 32'd0 : a - b;
  endfunction

endpackage

// ----- sv/pfa_front.sv -----
// ----------------------------------------------------------------------------
// pfa_front: request intake
// Decodes the function code of each item and holds it in a two-entry queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module pfa_front import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pfa_req_t req,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output pfa_cmd_t cmd
);

  pfa_cmd_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  pfa_cmd_t   decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.frame = req.frame[FRAME_BITS-1:0];
    decoded.count = req.count;
    unique case (req.func)
      FUNC_ALLOC:  decoded.op = OP_ALLOC;
      FUNC_FREE:   decoded.op = OP_FREE;
      FUNC_CONTIG: decoded.op = OP_CONTIG;
      FUNC_ZERO:   decoded.op = OP_ZERO;
      FUNC_ADD:    decoded.op = OP_ADD;
      default:     decoded.op = OP_NONE;
    endcase
  end

  assign req_ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- sv/pfa_back.sv -----
// ----------------------------------------------------------------------------
// pfa_back: allocation engine
// Sequencer over the region table and the dirty and zeroed frame stacks; it
// carries out one command at a time and registers its result item.
// ----------------------------------------------------------------------------
module pfa_back import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  pfa_cmd_t cmd,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pfa_rsp_t rsp
);

  pfa_state_e state, state_next;
  pfa_cmd_t   cur, cur_next;
  logic [REG_CW-1:0]   idx, idx_next;
  logic [REG_CW-1:0]   used, used_next;
  logic [DIRTY_CW-1:0] dirty_top, dirty_top_next;
  logic [POOL_CW-1:0]  pool_top, pool_top_next;
  logic [31:0] free_cnt, free_cnt_next;
  logic [31:0] min_free, min_free_next;
  logic [31:0] tz_sum, tz_sum_next;
  logic [31:0] fail_cnt, fail_cnt_next;
  logic        pop_pool, pop_pool_next;

  logic                  res_ok, res_ok_next;
  logic [FRAME_BITS-1:0] res_run, res_run_next;
  logic [31:0]           res_pages, res_pages_next;
  logic [31:0]           res_zero, res_zero_next;
  logic [1:0]            res_state, res_state_next;
  logic [1:0]            res_err, res_err_next;

  logic [FRAME_BITS-1:0] region_base [MAX_REGIONS];
  logic [31:0]           region_left [MAX_REGIONS];
  logic [31:0]           region_tail [MAX_REGIONS];

  logic [FRAME_BITS-1:0] dirty_mem [DIRTY_DEPTH];
  logic [FRAME_BITS-1:0] pool_mem [POOL_DEPTH];
  logic [FRAME_BITS-1:0] dirty_q, pool_q;

  logic                  dirty_re, dirty_we, pool_re, pool_we;
  logic [DIRTY_AW-1:0]   dirty_ra, dirty_wa;
  logic [POOL_AW-1:0]    pool_ra, pool_wa;
  logic [FRAME_BITS-1:0] dirty_wd, pool_wd;

  logic                  reg_we, base_we;
  logic [REG_AW-1:0]     reg_wa;
  logic [31:0]           left_w, tail_w;
  logic [FRAME_BITS-1:0] base_w;

  logic [REG_CW-1:0]     rd_full;
  logic [REG_AW-1:0]     rd;
  logic [31:0]           left_r, tail_r, pre, fc_new;
  logic [FRAME_BITS-1:0] base_r, popped;
  logic                  load_rsp;

  assign rd_full = (state == S_TRIM) ? used - 1'b1 : idx - 1'b1;
  assign rd      = rd_full[REG_AW-1:0];
  assign left_r  = region_left[rd];
  assign tail_r  = region_tail[rd];
  assign base_r  = region_base[rd];
  assign pre     = (tail_r < cur.count) ? tail_r : cur.count;
  assign popped  = pop_pool ? pool_q : dirty_q;

  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cur <= cmd;
    end else begin
      cur <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      used      <= '0;
      dirty_top <= '0;
      pool_top  <= '0;
      free_cnt  <= '0;
      min_free  <= '1;
      tz_sum    <= '0;
      fail_cnt  <= '0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      used      <= used_next;
      dirty_top <= dirty_top_next;
      pool_top  <= pool_top_next;
      free_cnt  <= free_cnt_next;
      min_free  <= min_free_next;
      tz_sum    <= tz_sum_next;
      fail_cnt  <= fail_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pop_pool  <= pop_pool_next;
    res_ok    <= res_ok_next;
    res_run   <= res_run_next;
    res_pages <= res_pages_next;
    res_zero  <= res_zero_next;
    res_state <= res_state_next;
    res_err   <= res_err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_REGIONS; i++) begin
        region_left[i] <= '0;
        region_tail[i] <= '0;
      end
    end else if (reg_we) begin
      region_left[reg_wa] <= left_w;
      region_tail[reg_wa] <= tail_w;
    end
  end

  always_ff @(posedge clk) begin
    if (base_we) begin
      region_base[reg_wa] <= base_w;
    end
  end

  always_ff @(posedge clk) begin
    if (dirty_we) begin
      dirty_mem[dirty_wa] <= dirty_wd;
    end
    if (dirty_re) begin
      dirty_q <= dirty_mem[dirty_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    if (pool_re) begin
      pool_q <= pool_mem[pool_ra];
    end
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    idx_next       = idx;
    used_next      = used;
    dirty_top_next = dirty_top;
    pool_top_next  = pool_top;
    free_cnt_next  = free_cnt;
    min_free_next  = min_free;
    tz_sum_next    = tz_sum;
    fail_cnt_next  = fail_cnt;
    pop_pool_next  = pop_pool;
    res_ok_next    = res_ok;
    res_run_next   = res_run;
    res_pages_next = res_pages;
    res_zero_next  = res_zero;
    res_state_next = res_state;
    res_err_next   = res_err;
    dirty_re = 1'b0;
    dirty_we = 1'b0;
    dirty_ra = DIRTY_AW'(dirty_top - 1'b1);
    dirty_wa = DIRTY_AW'(dirty_top);
    dirty_wd = cmd.frame;
    pool_re  = 1'b0;
    pool_we  = 1'b0;
    pool_ra  = POOL_AW'(pool_top - 1'b1);
    pool_wa  = POOL_AW'(pool_top);
    pool_wd  = dirty_q;
    reg_we   = 1'b0;
    base_we  = 1'b0;
    reg_wa   = rd;
    left_w   = left_r;
    tail_w   = tail_r;
    base_w   = cmd.frame;
    fc_new   = free_cnt;
    load_rsp = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          res_ok_next    = 1'b0;
          res_run_next   = '0;
          res_pages_next = '0;
          res_zero_next  = '0;
          res_state_next = ST_UNCHANGED;
          res_err_next   = ERR_NONE;
          idx_next       = used;
          state_next     = S_RESULT;
          unique case (cmd.op)
            OP_ALLOC: begin
              if (pool_top != '0) begin
                pool_re       = 1'b1;
                pool_top_next = pool_top - 1'b1;
                pop_pool_next = 1'b1;
                state_next    = S_POP;
              end else if (dirty_top != '0) begin
                dirty_re       = 1'b1;
                dirty_top_next = dirty_top - 1'b1;
                pop_pool_next  = 1'b0;
                state_next     = S_POP;
              end else begin
                state_next = S_TRIM;
              end
            end
            OP_FREE: begin
              res_run_next = cmd.frame;
              if (dirty_top < DIRTY_CW'(DIRTY_DEPTH)) begin
                dirty_we       = 1'b1;
                dirty_top_next = dirty_top + 1'b1;
                free_cnt_next  = sat_add32(free_cnt, 32'd1);
                res_ok_next    = 1'b1;
                res_pages_next = 32'd1;
                res_state_next = ST_FREE;
              end else begin
                res_err_next = ERR_REJECTED;
              end
            end
            OP_CONTIG: begin
              state_next = S_SCAN_C;
            end
            OP_ZERO: begin
              if (dirty_top != '0) begin
                dirty_re       = 1'b1;
                dirty_top_next = dirty_top - 1'b1;
                pop_pool_next  = 1'b0;
                state_next     = S_POP;
              end else if (33'(pool_top) + 33'(tz_sum) < 33'(free_cnt)) begin
                state_next = S_SCAN_Z;
              end
            end
            OP_ADD: begin
              if (used < REG_CW'(MAX_REGIONS)) begin
                reg_we         = 1'b1;
                base_we        = 1'b1;
                reg_wa         = REG_AW'(used);
                left_w         = cmd.count;
                tail_w         = '0;
                used_next      = used + 1'b1;
                free_cnt_next  = sat_add32(free_cnt, cmd.count);
                res_ok_next    = 1'b1;
                res_run_next   = cmd.frame;
                res_pages_next = cmd.count;
                res_state_next = ST_FREE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        res_ok_next  = 1'b1;
        res_run_next = popped;
        state_next   = S_RESULT;
        if (cur.op == OP_ALLOC) begin
          fc_new         = sat_sub32(free_cnt, 32'd1);
          free_cnt_next  = fc_new;
          min_free_next  = (fc_new < min_free) ? fc_new : min_free;
          res_pages_next = 32'd1;
          res_zero_next  = pop_pool ? 32'd0 : 32'd1;
          res_state_next = ST_ACTIVE;
        end else begin
          res_zero_next = 32'd1;
          if (pool_top < POOL_CW'(POOL_DEPTH)) begin
            pool_we        = 1'b1;
            pool_top_next  = pool_top + 1'b1;
            res_pages_next = 32'd1;
            res_state_next = ST_ZEROED;
          end else begin
            // The frame is still in place in the dirty stack; restore its top.
            dirty_top_next = dirty_top + 1'b1;
          end
        end
      end

      S_TRIM: begin
        if (used == '0) begin
          fail_cnt_next = sat_add32(fail_cnt, 32'd1);
          state_next    = S_RESULT;
        end else if (left_r == '0) begin
          used_next = used - 1'b1;
        end else begin
          reg_we = 1'b1;
          left_w = left_r - 32'd1;
          if (tail_r != '0) begin
            tail_w        = tail_r - 32'd1;
            tz_sum_next   = sat_sub32(tz_sum, 32'd1);
            res_zero_next = 32'd0;
          end else begin
            res_zero_next = 32'd1;
          end
          fc_new         = sat_sub32(free_cnt, 32'd1);
          free_cnt_next  = fc_new;
          min_free_next  = (fc_new < min_free) ? fc_new : min_free;
          res_ok_next    = 1'b1;
          res_run_next   = base_r + FRAME_BITS'(left_r - 32'd1);
          res_pages_next = 32'd1;
          res_state_next = ST_ACTIVE;
          state_next     = S_RESULT;
        end
      end

      S_SCAN_C: begin
        if (idx == '0) begin
          fail_cnt_next = sat_add32(fail_cnt, 32'd1);
          state_next    = S_RESULT;
        end else if (left_r < cur.count) begin
          idx_next = idx - 1'b1;
        end else begin
          reg_we         = 1'b1;
          left_w         = left_r - cur.count;
          tail_w         = tail_r - pre;
          tz_sum_next    = sat_sub32(tz_sum, pre);
          fc_new         = sat_sub32(free_cnt, cur.count);
          free_cnt_next  = fc_new;
          min_free_next  = (fc_new < min_free) ? fc_new : min_free;
          res_ok_next    = 1'b1;
          res_run_next   = base_r + FRAME_BITS'(left_r - cur.count);
          res_pages_next = cur.count;
          res_zero_next  = cur.count - pre;
          res_state_next = ST_ACTIVE;
          state_next     = S_RESULT;
        end
      end

      S_SCAN_Z: begin
        if (idx == '0) begin
          state_next = S_RESULT;
        end else if (tail_r >= left_r) begin
          idx_next = idx - 1'b1;
        end else begin
          reg_we         = 1'b1;
          tail_w         = tail_r + 32'd1;
          tz_sum_next    = sat_add32(tz_sum, 32'd1);
          res_ok_next    = 1'b1;
          res_run_next   = base_r + FRAME_BITS'(left_r - tail_r - 32'd1);
          res_pages_next = 32'd1;
          res_zero_next  = 32'd1;
          res_state_next = ST_ZEROED;
          state_next     = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.ok                <= res_ok;
      rsp.run_frame         <= 40'(res_run);
      rsp.run_pages         <= res_pages;
      rsp.zero_pages        <= res_zero;
      rsp.new_state         <= res_state;
      rsp.free_total        <= free_cnt;
      rsp.low_water_mark    <= min_free;
      rsp.dirty_depth_now   <= 11'(dirty_top);
      rsp.pool_depth_now    <= 11'(pool_top);
      rsp.tail_zeroed_total <= tz_sum;
      rsp.failure_total     <= fail_cnt;
      rsp.error_code        <= res_err;
    end
  end

endmodule

// ----- sv/page_frame_allocator_with_zero_pool.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_with_zero_pool: physical page allocator
// Frame allocator with dirty and zeroed frame stacks and a region table.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  pfa_req_t
//   rsp      out        rsp_valid / rsp_ready  pfa_rsp_t
//
// Free, add region and rejected requests go straight to the result state;
// stack pops pass through the pop state (registered stack memory read).
// Contiguous allocation, the region fallback of a page allocation and the
// zeroer walk the region table one entry per cycle. The two-entry queue takes
// requests while it has room, also while the engine works or a result is
// stalled. Reset empties the stacks and the region table, clears the counters.
// ----------------------------------------------------------------------------
module page_frame_allocator_with_zero_pool import pfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pfa_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pfa_rsp_t rsp
);

  logic     cmd_valid;
  logic     cmd_ready;
  pfa_cmd_t cmd;

  pfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- sv/pfa_checker.sv -----
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks of the page frame allocator
// Watches the result channel for stalls and for consistent result items.
// ----------------------------------------------------------------------------
module pfa_checker import pfa_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input pfa_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result item changed while stalled");

  // A failed item touches no descriptors.
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |->
      rsp.run_pages == 32'd0 && rsp.zero_pages == 32'd0 && rsp.new_state == ST_UNCHANGED)
    else $error("failed item reports a run");

  a_zeroed_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.new_state == ST_ZEROED |->
      rsp.ok && rsp.run_pages == 32'd1 && rsp.zero_pages == 32'd1)
    else $error("zeroed item is not a single cleared page");

  a_err_only_free: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code != ERR_NONE |->
      !rsp.ok && rsp.error_code == ERR_REJECTED && rsp.dirty_depth_now == 11'(DIRTY_DEPTH))
    else $error("error code without a full dirty stack");

endmodule

bind page_frame_allocator_with_zero_pool pfa_checker u_pfa_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
